/* hw/rtl/dskf_pkg.sv */
package dskf_pkg;

	localparam int SAMPLE_W = 24;
	localparam int CFG_W    = 16;
	localparam int IDX_W    = 3;
	localparam int FRAC     = 16;
	localparam int EST_W    = 40;
	localparam int VAR_W    = 34;
	localparam int PP_W     = 35;
	localparam int DEN_W    = 36;
	localparam int K_W      = 16;
	localparam int CNT_W    = 4;
	localparam int ALU_W    = 60;

	localparam logic [IDX_W-1:0] REG_Q_A  = 3'd0;
	localparam logic [IDX_W-1:0] REG_R_A  = 3'd1;
	localparam logic [IDX_W-1:0] REG_IV_A = 3'd2;
	localparam logic [IDX_W-1:0] REG_Q_B  = 3'd3;
	localparam logic [IDX_W-1:0] REG_R_B  = 3'd4;
	localparam logic [IDX_W-1:0] REG_IV_B = 3'd5;

	localparam logic [CFG_W-1:0] RST_Q_A  = 16'd9;
	localparam logic [CFG_W-1:0] RST_R_A  = 16'd41;
	localparam logic [CFG_W-1:0] RST_IV_A = 16'd90;
	localparam logic [CFG_W-1:0] RST_Q_B  = 16'd60;
	localparam logic [CFG_W-1:0] RST_R_B  = 16'd1100;
	localparam logic [CFG_W-1:0] RST_IV_B = 16'd600;

	typedef logic signed [ALU_W-1:0] word_t;

	typedef enum logic [1:0] {
		ALU_ADD,
		ALU_SUB,
		ALU_DIV,
		ALU_MAC
	} alu_op_t;

	typedef struct packed {
		logic [CFG_W-1:0] q_a;
		logic [CFG_W-1:0] r_a;
		logic [CFG_W-1:0] iv_a;
		logic [CFG_W-1:0] q_b;
		logic [CFG_W-1:0] r_b;
		logic [CFG_W-1:0] iv_b;
	} cfg_t;

	typedef struct packed {
		logic busy;
		logic done;
	} core_stat_t;

endpackage

/* hw/rtl/dskf_alu.sv */
module dskf_alu import dskf_pkg::*; (
	input  alu_op_t op,
	input  word_t   a,
	input  word_t   b,
	input  logic    bit_in,
	output word_t   res,
	output logic    nonneg
);

	word_t sh;
	word_t opb;
	logic  sub;

	always_comb begin
		sh  = a;
		opb = b;
		sub = 1'b0;
		unique case (op)
			ALU_ADD: begin
			end
			ALU_SUB: begin
				sub = 1'b1;
			end
			ALU_DIV: begin
				// shift remainder up, try the divisor
				sh  = {a[ALU_W-2:0], 1'b0};
				sub = 1'b1;
			end
			ALU_MAC: begin
				// shift partial product up, add operand if multiplier bit set
				sh  = {a[ALU_W-2:0], 1'b0};
				opb = bit_in ? b : '0;
			end
			default: begin
			end
		endcase
		res    = sub ? (sh - opb) : (sh + opb);
		nonneg = ~res[ALU_W-1];
	end

endmodule

/* hw/rtl/dskf_core.sv */
module dskf_core import dskf_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cfg_t                       cfg,
	input  logic                       start,
	input  logic signed [SAMPLE_W-1:0] za,
	input  logic signed [SAMPLE_W-1:0] zb,
	input  logic                       pick,
	input  logic                       out_free,
	output core_stat_t                 stat,
	output logic signed [SAMPLE_W-1:0] est_out
);

	typedef enum logic [10:0] {
		ST_IDLE = 11'b00000000001,
		ST_PP   = 11'b00000000010,
		ST_DEN  = 11'b00000000100,
		ST_DIV  = 11'b00000001000,
		ST_MULP = 11'b00000010000,
		ST_PNEW = 11'b00000100000,
		ST_DIFF = 11'b00001000000,
		ST_ABS  = 11'b00010000000,
		ST_MULD = 11'b00100000000,
		ST_CORR = 11'b01000000000,
		ST_FIN  = 11'b10000000000
	} state_t;

	state_t                     state_q;
	logic                       seeded_q;
	logic                       ch_q;
	logic [CNT_W-1:0]           cnt_q;

	logic signed [EST_W-1:0]    est_a_q, est_b_q;
	logic [VAR_W-1:0]           var_a_q, var_b_q;
	logic signed [SAMPLE_W-1:0] za_q, zb_q;
	logic                       pick_q;
	logic [PP_W-1:0]            pp_q;
	logic [DEN_W-1:0]           den_q;
	logic [K_W-1:0]             k_q;
	word_t                      rem_q, acc_q, mag_q;
	logic                       neg_q;

	logic [CFG_W-1:0]           cur_q, cur_r, cur_r1;
	logic signed [EST_W-1:0]    cur_x, sel_x;
	logic [VAR_W-1:0]           cur_p;
	logic signed [SAMPLE_W-1:0] cur_z;
	logic [CNT_W-1:0]           kidx;
	logic                       last;

	alu_op_t                    op;
	word_t                      opa, opb, res;
	logic                       kbit, nonneg;

	assign cur_q  = ch_q ? cfg.q_b : cfg.q_a;
	assign cur_r  = ch_q ? cfg.r_b : cfg.r_a;
	// zero noise is treated as one so the gain stays below unity
	assign cur_r1 = (cur_r == '0) ? CFG_W'(1) : cur_r;
	assign cur_x  = ch_q ? est_b_q : est_a_q;
	assign cur_p  = ch_q ? var_b_q : var_a_q;
	assign cur_z  = ch_q ? zb_q : za_q;
	assign kidx   = CNT_W'(K_W - 1) - cnt_q;
	assign kbit   = k_q[kidx];
	assign last   = (cnt_q == CNT_W'(K_W - 1));

	always_comb begin
		op  = ALU_ADD;
		opa = '0;
		opb = '0;
		unique case (state_q)
			ST_PP: begin
				opa = {{(ALU_W-VAR_W){1'b0}}, cur_p};
				opb = {{(ALU_W-CFG_W-FRAC){1'b0}}, cur_q, {FRAC{1'b0}}};
			end
			ST_DEN: begin
				opa = {{(ALU_W-PP_W){1'b0}}, pp_q};
				opb = {{(ALU_W-CFG_W-FRAC){1'b0}}, cur_r1, {FRAC{1'b0}}};
			end
			ST_DIV: begin
				op  = ALU_DIV;
				opa = rem_q;
				opb = {{(ALU_W-DEN_W){1'b0}}, den_q};
			end
			ST_MULP: begin
				op  = ALU_MAC;
				opa = acc_q;
				opb = {{(ALU_W-PP_W){1'b0}}, pp_q};
			end
			ST_PNEW: begin
				// (1-K)P' = P'<<16 - K*P'
				op  = ALU_SUB;
				opa = {{(ALU_W-PP_W-FRAC){1'b0}}, pp_q, {FRAC{1'b0}}};
				opb = acc_q;
			end
			ST_DIFF: begin
				op  = ALU_SUB;
				opa = {{(ALU_W-SAMPLE_W-FRAC){cur_z[SAMPLE_W-1]}}, cur_z, {FRAC{1'b0}}};
				opb = {{(ALU_W-EST_W){cur_x[EST_W-1]}}, cur_x};
			end
			ST_ABS: begin
				op  = ALU_SUB;
				opb = mag_q;
			end
			ST_MULD: begin
				op  = ALU_MAC;
				opa = acc_q;
				opb = mag_q;
			end
			ST_CORR: begin
				// apply magnitude of the correction with the sign of the innovation
				op  = neg_q ? ALU_SUB : ALU_ADD;
				opa = {{(ALU_W-EST_W){cur_x[EST_W-1]}}, cur_x};
				opb = {{FRAC{1'b0}}, acc_q[ALU_W-1:FRAC]};
			end
			default: begin
			end
		endcase
	end

	dskf_alu u_alu (
		.op     (op),
		.a      (opa),
		.b      (opb),
		.bit_in (kbit),
		.res    (res),
		.nonneg (nonneg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			seeded_q <= 1'b0;
			ch_q     <= 1'b0;
			cnt_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						seeded_q <= 1'b1;
						ch_q     <= 1'b0;
						state_q  <= ST_PP;
					end
				end
				ST_PP:   state_q <= ST_DEN;
				ST_DEN: begin
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (last) begin
						state_q <= ST_MULP;
					end
				end
				ST_MULP: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (last) begin
						state_q <= ST_PNEW;
					end
				end
				ST_PNEW: state_q <= ST_DIFF;
				ST_DIFF: state_q <= ST_ABS;
				ST_ABS: begin
					cnt_q   <= '0;
					state_q <= ST_MULD;
				end
				ST_MULD: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (last) begin
						state_q <= ST_CORR;
					end
				end
				ST_CORR: begin
					if (ch_q) begin
						state_q <= ST_FIN;
					end else begin
						ch_q    <= 1'b1;
						state_q <= ST_PP;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					za_q   <= za;
					zb_q   <= zb;
					pick_q <= pick;
					if (!seeded_q) begin
						est_a_q <= {za, {FRAC{1'b0}}};
						est_b_q <= {zb, {FRAC{1'b0}}};
						var_a_q <= {{(VAR_W-CFG_W-FRAC){1'b0}}, cfg.iv_a, {FRAC{1'b0}}};
						var_b_q <= {{(VAR_W-CFG_W-FRAC){1'b0}}, cfg.iv_b, {FRAC{1'b0}}};
					end
				end
			end
			ST_PP: begin
				pp_q <= res[PP_W-1:0];
			end
			ST_DEN: begin
				den_q <= res[DEN_W-1:0];
				rem_q <= {{(ALU_W-PP_W){1'b0}}, pp_q};
				k_q   <= '0;
			end
			ST_DIV: begin
				rem_q <= nonneg ? res : {rem_q[ALU_W-2:0], 1'b0};
				k_q   <= {k_q[K_W-2:0], nonneg};
				acc_q <= '0;
			end
			ST_MULP: begin
				acc_q <= res;
			end
			ST_PNEW: begin
				if (ch_q) begin
					var_b_q <= res[FRAC+VAR_W-1:FRAC];
				end else begin
					var_a_q <= res[FRAC+VAR_W-1:FRAC];
				end
			end
			ST_DIFF: begin
				mag_q <= res;
				neg_q <= res[ALU_W-1];
			end
			ST_ABS: begin
				if (neg_q) begin
					mag_q <= res;
				end
				acc_q <= '0;
			end
			ST_MULD: begin
				acc_q <= res;
			end
			ST_CORR: begin
				if (ch_q) begin
					est_b_q <= res[EST_W-1:0];
				end else begin
					est_a_q <= res[EST_W-1:0];
				end
			end
			ST_FIN: begin
			end
			default: begin
			end
		endcase
	end

	// integer part, truncated toward zero
	assign sel_x   = pick_q ? est_a_q : est_b_q;
	assign est_out = sel_x[EST_W-1:FRAC]
		+ SAMPLE_W'(sel_x[EST_W-1] && (sel_x[FRAC-1:0] != '0));

	assign stat.busy = (state_q != ST_IDLE);
	assign stat.done = (state_q == ST_FIN) && out_free;

endmodule

/* hw/rtl/dual_scalar_kalman_filter.sv */
// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  sample_a, sample_b, pick_a
// output    out        out_valid / out_stall estimate
// config    in         cfg_write            cfg_index, cfg_data
//
// From its transfer to its result entering the output register, one item takes
// both channels through one shared 60-bit add/subtract unit, each with two
// set-up adds, a 16-step restoring divide for the gain, two 16-step shift-add
// multiplies and four single adds, and then a final step to finish.
// The next item is taken the cycle after the result is registered, while that
// result may still wait on out_stall; a stalled result holds the sequencer in
// its final step. Reset restores the register defaults and clears the seed flag.
module dual_scalar_kalman_filter import dskf_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [SAMPLE_W-1:0] sample_a,
	input  logic signed [SAMPLE_W-1:0] sample_b,
	input  logic                       pick_a,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [SAMPLE_W-1:0] estimate,
	input  logic                       cfg_write,
	input  logic [IDX_W-1:0]           cfg_index,
	input  logic [CFG_W-1:0]           cfg_data
);

	cfg_t                       cfg_q;
	core_stat_t                 stat;
	logic                       start;
	logic                       out_free;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] estimate_q;
	logic signed [SAMPLE_W-1:0] est_out;

	// register writes; unknown indexes drop silently
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.q_a  <= RST_Q_A;
			cfg_q.r_a  <= RST_R_A;
			cfg_q.iv_a <= RST_IV_A;
			cfg_q.q_b  <= RST_Q_B;
			cfg_q.r_b  <= RST_R_B;
			cfg_q.iv_b <= RST_IV_B;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_Q_A:  cfg_q.q_a  <= cfg_data;
				REG_R_A:  cfg_q.r_a  <= cfg_data;
				REG_IV_A: cfg_q.iv_a <= cfg_data;
				REG_Q_B:  cfg_q.q_b  <= cfg_data;
				REG_R_B:  cfg_q.r_b  <= cfg_data;
				REG_IV_B: cfg_q.iv_b <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// take a new item only while the sequencer is idle
	assign in_stall = stat.busy;
	assign start    = in_valid && !stat.busy;

	// output slot is free when empty or being drained this cycle
	assign out_free = !out_valid_q || !out_stall;

	dskf_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.start    (start),
		.za       (sample_a),
		.zb       (sample_b),
		.pick     (pick_a),
		.out_free (out_free),
		.stat     (stat),
		.est_out  (est_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (stat.done) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// hold the result until its transfer
	always_ff @(posedge clk) begin
		if (stat.done) begin
			estimate_q <= est_out;
		end
	end

	assign out_valid = out_valid_q;
	assign estimate  = estimate_q;

endmodule
